// File: sv/trilinear_hex_inverse_map_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trilinear hex inverse map block
// Shared property wrappers used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef TRILINEAR_HEX_INVERSE_MAP_TOP_ASSERT_SVH
`define TRILINEAR_HEX_INVERSE_MAP_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define THIM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define THIM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/thim_pkg.sv
// ----------------------------------------------------------------------------
// thim_pkg
// Shared types and constants for the trilinear hex inverse map block.
// ----------------------------------------------------------------------------
`default_nettype none
package thim_pkg;
    localparam int MAX_ITER_DEF    = 32;
    localparam int COORD_WIDTH_DEF = 32;
    localparam logic [31:0] TOL_RESET = 32'd66;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_CAP       = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV  = 2'd2;

    // natural sign of corner i along an axis: 1 means +
    localparam logic [7:0] SIGN_XI  = 8'b0110_0110;
    localparam logic [7:0] SIGN_ETA = 8'b1100_1100;
    localparam logic [7:0] SIGN_MU  = 8'b1111_0000;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } thim_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } thim_div_rsp_t;
endpackage
`default_nettype wire

// File: sv/thim_divider.sv
// ----------------------------------------------------------------------------
// thim_divider
// Sequential signed divide giving a Q28 quotient, magnitude truncated,
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module thim_divider
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire thim_pkg::thim_div_req_t req,
    output thim_pkg::thim_div_rsp_t      rsp
);
    import thim_pkg::*;

    // 64 integer + 28 fraction quotient bits; remainder kept at 65 bits
    logic [63:0] ud_reg;
    logic [64:0] rem_reg;
    logic [91:0] q_reg;
    logic [91:0] nd_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [31:0] quot_reg;

    logic [63:0] un_abs;
    logic [63:0] ud_abs;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        take;
    logic [91:0] q_new;
    logic [31:0] mag;
    logic [31:0] quot_next;

    assign un_abs  = req.num[63] ? (64'd0 - req.num) : req.num;
    assign ud_abs  = req.den[63] ? (64'd0 - req.den) : req.den;
    assign rem_sh  = {rem_reg[63:0], nd_reg[91]};
    assign take    = rem_sh >= {1'b0, ud_reg};
    assign rem_sub = take ? (rem_sh - {1'b0, ud_reg}) : rem_sh;
    assign q_new   = {q_reg[90:0], take};

    always_comb
    begin
        // integer part 8 or more saturates
        if (q_new[91:31] != '0)
        begin
            mag = 32'h8000_0000;
        end
        else
        begin
            mag = {1'b0, q_new[30:0]};
        end
        if (neg_reg)
        begin
            quot_next = 32'd0 - mag;
        end
        else
        begin
            quot_next = mag[31] ? 32'h7FFF_FFFF : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd91;
                neg_reg  <= req.num[63] ^ req.den[63];
                ud_reg   <= ud_abs;
                nd_reg   <= {un_abs, 28'd0};
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_sub;
                q_reg   <= q_new;
                nd_reg  <= {nd_reg[90:0], 1'b0};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= quot_next;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `include "trilinear_hex_inverse_map_top_assert.svh"
    `THIM_ASSERT_NXT(a_div_done_clr, clk, rst_n, req.start, !rsp.done, "done right after start")
    `THIM_ASSERT_IMP(a_div_idle_done, clk, rst_n, rsp.done, !busy_reg, "done while busy")
    `THIM_ASSERT_NXT(a_div_busy, clk, rst_n, req.start, busy_reg, "start did not load")
endmodule
`default_nettype wire

// File: sv/trilinear_hex_inverse_map_top.sv
// ----------------------------------------------------------------------------
// trilinear_hex_inverse_map_top
// Inverse trilinear map of a point in a hexahedron to natural coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries input transactions. tuser = is_query; tdata holds
//   corner_index, coord_x, coord_y, coord_z from bit 0 up. A corner load
//   writes the corner store and gives no result. A query solves
//   for (xi, eta, mu) and gives one m_axis transaction with tdata
//   nat_xi, nat_eta, nat_mu, passes_used from bit 0 up and tuser = status.
//   Each pass runs three solves (8 weight products, 8 weighted corners and
//   one divide each) and a forward check (16 weight products plus 24
//   corner products), all on one 34x34 multiplier, one product per cycle.
//   A query runs passes until the forward check converges or MAX_ITER
//   passes are used. s_axis_tready is low while a query is solved or its
//   result waits. tolerance is written by cfg_we.
//   Reset clears control and sets tolerance to 66; the corner store is not
//   cleared. A stalled m_axis holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module trilinear_hex_inverse_map_top
#(
    parameter int MAX_ITER    = thim_pkg::MAX_ITER_DEF,
    parameter int COORD_WIDTH = thim_pkg::COORD_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // corner_index[2:0], coord_x[34:3], coord_y[66:35], coord_z[98:67], zero pad
    input  wire logic [103:0] s_axis_tdata,
    // is_query
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // nat_xi[31:0], nat_eta[63:32], nat_mu[95:64], passes_used[106:96], pad
    output logic [111:0]      m_axis_tdata,
    // status
    output logic [1:0]        m_axis_tuser
);
    import thim_pkg::*;

    localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int PW = $clog2(MAX_ITER + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SW, S_SC, S_DIVS, S_DIVW, S_FW1, S_FW2, S_FC, S_CHK, S_OUT
    } state_t;

    state_t       state_reg;
    logic [31:0]  tol_reg;
    logic [31:0]  cx_mem [8];
    logic [31:0]  cy_mem [8];
    logic [31:0]  cz_mem [8];
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] n_reg [3];
    logic [1:0]   axis_reg;
    logic [2:0]   idx_reg;
    logic [1:0]   sub_reg;
    logic signed [63:0] w_reg;
    logic signed [63:0] sum_reg, den_reg;
    logic signed [63:0] acc_reg [3];
    logic [PW-1:0] pass_reg;
    logic [1:0]   status_reg;
    logic [31:0]  r_cx, r_cy, r_cz;

    thim_div_req_t dreq;
    thim_div_rsp_t drsp;

    thim_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic signed [31:0] sext(input logic [31:0] v);
        logic [31:0] m;
        m = (CW >= 32) ? 32'hFFFF_FFFF : ((32'd1 << CW) - 32'd1);
        sext = signed'((v & m) | ((v[CW-1]) ? ~m : 32'd0));
    endfunction

    function automatic logic sgn(input logic [1:0] ax, input logic [2:0] i);
        case (ax)
            2'd0:    sgn = SIGN_XI[i];
            2'd1:    sgn = SIGN_ETA[i];
            default: sgn = SIGN_MU[i];
        endcase
    endfunction

    function automatic logic signed [63:0] fac(input logic s, input logic signed [31:0] n);
        fac = s ? (64'sd268435456 + 64'(n)) : (64'sd268435456 - 64'(n));
    endfunction

    // the other two axes held during a solve
    logic [1:0] ax_b, ax_c;
    assign ax_b = (axis_reg == 2'd0) ? 2'd1 : 2'd0;
    assign ax_c = (axis_reg == 2'd2) ? 2'd1 : 2'd2;

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod;
    logic signed [63:0] corner_val;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    corner_val = 64'(signed'(r_cx));
            2'd1:    corner_val = 64'(signed'(r_cy));
            default: corner_val = 64'(signed'(r_cz));
        endcase
        mul_a = 34'(w_reg);
        mul_b = '0;
        unique case (state_reg)
            S_SW:
            begin
                mul_a = 34'(fac(sgn(ax_b, idx_reg), n_reg[ax_b]));
                mul_b = 34'(fac(sgn(ax_c, idx_reg), n_reg[ax_c]));
            end
            S_SC: mul_b = corner_val[33:0];
            S_FW1:
            begin
                mul_a = 34'(fac(sgn(2'd0, idx_reg), n_reg[0]));
                mul_b = 34'(fac(sgn(2'd1, idx_reg), n_reg[1]));
            end
            S_FW2: mul_b = 34'(fac(sgn(2'd2, idx_reg), n_reg[2]));
            S_FC:
            begin
                unique case (sub_reg)
                    2'd0:    mul_b = 34'(signed'(r_cx));
                    2'd1:    mul_b = 34'(signed'(r_cy));
                    default: mul_b = 34'(signed'(r_cz));
                endcase
            end
            default: mul_b = '0;
        endcase
    end

    // factors reach 2^31 + 2^28 and weights stay below 2^28, so 34 bits hold both
    assign prod = 68'(mul_a) * 68'(mul_b);

    logic signed [63:0] point_axis;
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    point_axis = 64'(px_reg);
            2'd1:    point_axis = 64'(py_reg);
            default: point_axis = 64'(pz_reg);
        endcase
    end

    // forward error check
    logic signed [63:0] e [3];
    logic [63:0] ea [3];
    logic conv;
    always_comb
    begin
        e[0] = (acc_reg[0] >>> 21) - 64'(px_reg);
        e[1] = (acc_reg[1] >>> 21) - 64'(py_reg);
        e[2] = (acc_reg[2] >>> 21) - 64'(pz_reg);
        for (int k = 0; k < 3; k++)
        begin
            ea[k] = e[k][63] ? (64'd0 - e[k]) : e[k];
        end
        conv = (ea[0] <= 64'(tol_reg)) && (ea[1] <= 64'(tol_reg))
            && (ea[2] <= 64'(tol_reg));
    end

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        r_cx <= cx_mem[idx_reg];
        r_cy <= cy_mem[idx_reg];
        r_cz <= cz_mem[idx_reg];
        if (s_acc && !s_axis_tuser)
        begin
            cx_mem[s_axis_tdata[2:0]] <= 32'(sext(s_axis_tdata[34:3]));
            cy_mem[s_axis_tdata[2:0]] <= 32'(sext(s_axis_tdata[66:35]));
            cz_mem[s_axis_tdata[2:0]] <= 32'(sext(s_axis_tdata[98:67]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_RESET;
            m_axis_tvalid <= 1'b0;
            dreq.start    <= 1'b0;
            n_reg[0] <= '0;
            n_reg[1] <= '0;
            n_reg[2] <= '0;
        end
        else
        begin
            dreq.start <= 1'b0;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_acc && s_axis_tuser)
                    begin
                        px_reg   <= sext(s_axis_tdata[34:3]);
                        py_reg   <= sext(s_axis_tdata[66:35]);
                        pz_reg   <= sext(s_axis_tdata[98:67]);
                        n_reg[0] <= '0;
                        n_reg[1] <= '0;
                        n_reg[2] <= '0;
                        pass_reg <= PW'(1);
                        axis_reg <= 2'd0;
                        idx_reg  <= 3'd0;
                        sum_reg  <= '0;
                        den_reg  <= '0;
                        state_reg <= S_SW;
                    end
                end
                S_SW:
                begin
                    // Q56 product to Q20 weight; corner read settles meanwhile
                    w_reg     <= 64'(prod >>> 36);
                    state_reg <= S_SC;
                end
                S_SC:
                begin
                    sum_reg <= sum_reg + prod[63:0];
                    den_reg <= sgn(axis_reg, idx_reg) ? den_reg + prod[63:0]
                                                      : den_reg - prod[63:0];
                    if (idx_reg == 3'd7)
                    begin
                        state_reg <= S_DIVS;
                    end
                    else
                    begin
                        state_reg <= S_SW;
                    end
                    idx_reg <= idx_reg + 3'd1;
                end
                S_DIVS:
                begin
                    if (den_reg == '0)
                    begin
                        status_reg    <= ST_ZERO_DIV;
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        dreq.start <= 1'b1;
                        dreq.num   <= (point_axis <<< 23) - sum_reg;
                        dreq.den   <= den_reg;
                        state_reg  <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (drsp.done)
                    begin
                        n_reg[axis_reg] <= drsp.quot;
                        sum_reg <= '0;
                        den_reg <= '0;
                        idx_reg <= 3'd0;
                        if (axis_reg == 2'd2)
                        begin
                            acc_reg[0] <= '0;
                            acc_reg[1] <= '0;
                            acc_reg[2] <= '0;
                            state_reg  <= S_FW1;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_SW;
                        end
                    end
                end
                S_FW1:
                begin
                    w_reg     <= 64'(prod >>> 36);
                    state_reg <= S_FW2;
                end
                S_FW2:
                begin
                    w_reg     <= 64'(prod >>> 30);
                    sub_reg   <= 2'd0;
                    state_reg <= S_FC;
                end
                S_FC:
                begin
                    acc_reg[sub_reg] <= acc_reg[sub_reg] + prod[63:0];
                    if (sub_reg == 2'd2)
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= (idx_reg == 3'd7) ? S_CHK : S_FW1;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 2'd1;
                    end
                end
                S_CHK:
                begin
                    if (conv || (32'(pass_reg) >= 32'(MAX_ITER)))
                    begin
                        status_reg    <= conv ? ST_CONVERGED : ST_CAP;
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + PW'(1);
                        axis_reg  <= 2'd0;
                        state_reg <= S_SW;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {5'd0, 11'(pass_reg), n_reg[2], n_reg[1], n_reg[0]};
    assign m_axis_tuser = status_reg;

    `include "trilinear_hex_inverse_map_top_assert.svh"
    `THIM_ASSERT_IMP(a_out_state, clk, rst_n, m_axis_tvalid, state_reg == S_OUT, "valid outside output state")
    `THIM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_axis_tready, "ready while busy")
    `THIM_ASSERT_IMP(a_div_wait, clk, rst_n, drsp.done, state_reg == S_DIVW, "divide result unexpected")
endmodule
`default_nettype wire
